>>> rtl/core/assert_macros.svh
// Assertion helpers; empty when SYNTHESIS is defined.
// Both macros expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HFC_ASSERT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define HFC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HFC_ASSERT(lbl, pre, post, msg)
`define HFC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> rtl/core/hfc_pkg.sv
package hfc_pkg;

    localparam int SYMBOLS_DEF       = 256;
    localparam int COUNT_BITS_DEF    = 32;
    localparam int MAX_CODE_BITS_DEF = 64;

    localparam int CODE_WORD_BITS = 64;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_ENCODE = 2'd2,
        OP_DECODE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_BUILD = 2'd0,
        KIND_CODE  = 2'd1,
        KIND_SYM   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_TREE  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_ABSENT   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  symbol;
        logic [31:0] frequency;
        logic        coded_bit;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                kind;
        logic [1:0]                status;
        logic [7:0]                out_symbol;
        logic [CODE_WORD_BITS-1:0] code_word;
        logic [6:0]                code_length;
        logic [8:0]                leaf_count;
    } rsp_t;

endpackage

>>> rtl/core/hfc_ram.sv
module hfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [ABITS-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [ABITS-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/huffman_tree_codec.sv
// Channel | Dir | Handshake           | Beat
// cmd     | in  | cmd_valid/cmd_ready | hfc_pkg::cmd_t (opcode, symbol, frequency, coded_bit)
// rsp     | out | rsp_valid/rsp_ready | hfc_pkg::rsp_t (kind, status, out_symbol, ...)
//
// One command at a time; cmd_ready is high only while the sequencer is idle. Load writes
// the count RAM directly; decode answers with no tree, a single leaf or on reaching a leaf.
// Encode: answers directly with no tree or an absent symbol, else walks leaf to root.
// Build: (leaves + 1) sort passes over the count RAM, then one merge at a time
// on the shared weight RAM read port.
// Reset: the count RAM is cleared first. A stalled rsp side blocks the
// sequencer only when a second result is ready while one beat waits in rsp.
`include "assert_macros.svh"

module huffman_tree_codec #(
    parameter int SYMBOLS       = hfc_pkg::SYMBOLS_DEF,
    parameter int COUNT_BITS    = hfc_pkg::COUNT_BITS_DEF,
    parameter int MAX_CODE_BITS = hfc_pkg::MAX_CODE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  hfc_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output hfc_pkg::rsp_t rsp
);

    import hfc_pkg::*;

    localparam int NODES     = 2 * SYMBOLS - 1;
    localparam int SB        = $clog2(SYMBOLS);
    localparam int NB        = $clog2(NODES);
    localparam int WB        = COUNT_BITS + SB;       // merged weight width
    localparam int KID_DEPTH = SYMBOLS - 1;
    localparam int KB        = (KID_DEPTH > 1) ? $clog2(KID_DEPTH) : 1;
    localparam int LB        = (NB + 1 > 8) ? NB + 1 : 8;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_NEXT,
        S_MRG_CHK,
        S_MRG_RDO,
        S_MRG_RDL,
        S_MRG_RDI,
        S_MRG_PICK,
        S_MRG_WR0,
        S_MRG_WR1,
        S_ENC_RDW,
        S_ENC_CHKW,
        S_ENC_STEP,
        S_ENC_RDP,
        S_DEC_RD,
        S_DEC_PICK,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    rsp_t   rsp_reg, rsp_next, res_reg, res_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // sort
    logic [SB:0]           scan_reg, scan_next;
    logic                  have_prev_reg, have_prev_next;
    logic [COUNT_BITS-1:0] prev_w_reg, prev_w_next;
    logic [SB-1:0]         prev_s_reg, prev_s_next;
    logic                  found_reg, found_next;
    logic [COUNT_BITS-1:0] best_w_reg, best_w_next;
    logic [SB-1:0]         best_s_reg, best_s_next;
    logic [SB:0]           nleaf_reg, nleaf_next;

    // merge
    logic [SB:0]   lh_reg, lh_next;
    logic [NB-1:0] ih_reg, ih_next;
    logic [NB-1:0] nx_reg, nx_next;
    logic          take_reg, take_next;
    logic [NB-1:0] a_reg, a_next, b_reg, b_next;
    logic [WB-1:0] wa_reg, wa_next, wb_reg, wb_next;
    logic [SB-1:0] lsym_reg, lsym_next;
    logic [WB-1:0] lw_reg, lw_next;

    // tree / walk
    logic                      ready_reg, ready_next;
    logic [NB-1:0]             root_reg, root_next;
    logic [NB-1:0]             cursor_reg, cursor_next;
    logic [NB-1:0]             cur_reg, cur_next;
    logic [LB-1:0]             len_reg, len_next;
    logic [CODE_WORD_BITS-1:0] word_reg, word_next;

    // RAM ports
    logic                  cnt_we;
    logic [SB-1:0]         cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
    logic                  wgt_we;
    logic [NB-1:0]         wgt_waddr, wgt_raddr;
    logic [WB-1:0]         wgt_wdata, wgt_rdata;
    logic                  par_we;
    logic [NB-1:0]         par_waddr, par_raddr;
    logic [NB:0]           par_wdata, par_rdata;   // {parent, is one child}
    logic                  kid_we;
    logic [KB-1:0]         kid_waddr, kid_raddr;
    logic [2*NB-1:0]       kid_wdata, kid_rdata;   // {zero child, one child}
    logic                  ord_we;
    logic [SB-1:0]         ord_waddr, ord_raddr;
    logic [SB-1:0]         ord_wdata, ord_rdata;

    hfc_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOLS)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata));
    hfc_ram #(.WIDTH(WB), .DEPTH(NODES)) u_wgt (
        .clk(clk), .we(wgt_we), .waddr(wgt_waddr), .wdata(wgt_wdata),
        .raddr(wgt_raddr), .rdata(wgt_rdata));
    hfc_ram #(.WIDTH(NB + 1), .DEPTH(NODES)) u_par (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata));
    hfc_ram #(.WIDTH(2 * NB), .DEPTH(KID_DEPTH)) u_kid (
        .clk(clk), .we(kid_we), .waddr(kid_waddr), .wdata(kid_wdata),
        .raddr(kid_raddr), .rdata(kid_rdata));
    hfc_ram #(.WIDTH(SB), .DEPTH(SYMBOLS)) u_ord (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata));

    logic          accept;
    logic          root_leaf;
    logic          sym_in_range;
    logic          key_above_prev;
    logic          leaf_ok, int_ok, pick_leaf;
    logic [NB-1:0] pick_node;
    logic [WB-1:0] pick_w;
    logic [NB-1:0] dec_next;

    assign cmd_ready    = (state_reg == S_IDLE);
    assign accept       = cmd_valid && cmd_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;
    assign root_leaf    = (root_reg < NB'(SYMBOLS));
    assign sym_in_range = ({1'b0, cmd.symbol} < 9'(SYMBOLS));

    // (count, symbol) strictly above the last key taken by the sort
    assign key_above_prev = !have_prev_reg || (cnt_rdata > prev_w_reg) ||
                            ((cnt_rdata == prev_w_reg) && (scan_reg[SB-1:0] > prev_s_reg));

    // leaves win ties against merged nodes
    assign leaf_ok   = (lh_reg < nleaf_reg);
    assign int_ok    = (ih_reg < nx_reg);
    assign pick_leaf = leaf_ok && (!int_ok || (lw_reg <= wgt_rdata));
    assign pick_node = pick_leaf ? NB'(lsym_reg) : ih_reg;
    assign pick_w    = pick_leaf ? lw_reg : wgt_rdata;

    assign dec_next = cmd_reg.coded_bit ? kid_rdata[NB-1:0] : kid_rdata[2*NB-1:NB];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        rsp_next       = rsp_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        scan_next      = scan_reg;
        have_prev_next = have_prev_reg;
        prev_w_next    = prev_w_reg;
        prev_s_next    = prev_s_reg;
        found_next     = found_reg;
        best_w_next    = best_w_reg;
        best_s_next    = best_s_reg;
        nleaf_next     = nleaf_reg;
        lh_next        = lh_reg;
        ih_next        = ih_reg;
        nx_next        = nx_reg;
        take_next      = take_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        lsym_next      = lsym_reg;
        lw_next        = lw_reg;
        ready_next     = ready_reg;
        root_next      = root_reg;
        cursor_next    = cursor_reg;
        cur_next       = cur_reg;
        len_next       = len_reg;
        word_next      = word_reg;

        cnt_we    = 1'b0;
        cnt_waddr = scan_reg[SB-1:0];
        cnt_wdata = '0;
        cnt_raddr = scan_reg[SB-1:0];
        wgt_we    = 1'b0;
        wgt_waddr = NB'(scan_reg[SB-1:0]);
        wgt_wdata = WB'(cnt_rdata);
        wgt_raddr = ih_reg;
        par_we    = 1'b0;
        par_waddr = a_reg;
        par_wdata = {nx_reg, 1'b0};
        par_raddr = cur_reg;
        kid_we    = 1'b0;
        kid_waddr = KB'(nx_reg - NB'(SYMBOLS));
        kid_wdata = {a_reg, b_reg};
        kid_raddr = KB'(cursor_reg - NB'(SYMBOLS));
        ord_we    = 1'b0;
        ord_waddr = nleaf_reg[SB-1:0];
        ord_wdata = best_s_reg;
        ord_raddr = lh_reg[SB-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == (SB+1)'(SYMBOLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    unique case (cmd.opcode)
                        OP_LOAD:
                        begin
                            cnt_we    = sym_in_range;
                            cnt_waddr = cmd.symbol[SB-1:0];
                            cnt_wdata = cmd.frequency[COUNT_BITS-1:0];
                        end
                        OP_BUILD:
                        begin
                            scan_next      = '0;
                            have_prev_next = 1'b0;
                            found_next     = 1'b0;
                            nleaf_next     = '0;
                            state_next     = S_SORT_RD;
                        end
                        OP_ENCODE:
                        begin
                            res_next.kind = KIND_CODE;
                            if (!ready_reg)
                            begin
                                res_next.status = ST_NO_TREE;
                                state_next      = S_EMIT;
                            end
                            else if (!sym_in_range)
                            begin
                                res_next.status = ST_ABSENT;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_ENC_RDW;
                            end
                        end
                        OP_DECODE:
                        begin
                            res_next.kind = KIND_SYM;
                            if (!ready_reg)
                            begin
                                res_next.status = ST_NO_TREE;
                                state_next      = S_EMIT;
                            end
                            else if (root_leaf)
                            begin
                                res_next.out_symbol = 8'(root_reg[SB-1:0]);
                                state_next          = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_DEC_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // selection sort: each pass finds the smallest key above the last
            S_SORT_RD:
            begin
                state_next = S_SORT_CMP;
            end

            S_SORT_CMP:
            begin
                // first pass snapshots the leaf weights
                wgt_we = !have_prev_reg;
                if ((cnt_rdata != '0) && key_above_prev &&
                    (!found_reg || (cnt_rdata < best_w_reg)))
                begin
                    found_next  = 1'b1;
                    best_w_next = cnt_rdata;
                    best_s_next = scan_reg[SB-1:0];
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == (SB+1)'(SYMBOLS - 1))
                begin
                    state_next = S_SORT_NEXT;
                end
                else
                begin
                    state_next = S_SORT_RD;
                end
            end

            S_SORT_NEXT:
            begin
                if (found_reg)
                begin
                    ord_we         = 1'b1;
                    nleaf_next     = nleaf_reg + 1'b1;
                    prev_w_next    = best_w_reg;
                    prev_s_next    = best_s_reg;
                    have_prev_next = 1'b1;
                    found_next     = 1'b0;
                    scan_next      = '0;
                    state_next     = S_SORT_RD;
                end
                else
                begin
                    res_next.kind       = KIND_BUILD;
                    res_next.leaf_count = 9'(nleaf_reg);
                    if (nleaf_reg == '0)
                    begin
                        res_next.status = ST_NO_TREE;
                        ready_next      = 1'b0;
                        root_next       = '0;
                        cursor_next     = '0;
                        state_next      = S_EMIT;
                    end
                    else if (nleaf_reg == (SB+1)'(1))
                    begin
                        ready_next  = 1'b1;
                        root_next   = NB'(prev_s_reg);
                        cursor_next = NB'(prev_s_reg);
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        lh_next    = '0;
                        ih_next    = NB'(SYMBOLS);
                        nx_next    = NB'(SYMBOLS);
                        take_next  = 1'b0;
                        state_next = S_MRG_CHK;
                    end
                end
            end

            S_MRG_CHK:
            begin
                if (nx_reg == NB'(SYMBOLS) + NB'(nleaf_reg) - NB'(1))
                begin
                    ready_next  = 1'b1;
                    root_next   = nx_reg - NB'(1);
                    cursor_next = nx_reg - NB'(1);
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_MRG_RDO;
                end
            end

            S_MRG_RDO:
            begin
                state_next = S_MRG_RDL;
            end

            S_MRG_RDL:
            begin
                wgt_raddr  = NB'(ord_rdata);
                lsym_next  = ord_rdata;
                state_next = S_MRG_RDI;
            end

            S_MRG_RDI:
            begin
                lw_next    = wgt_rdata;
                state_next = S_MRG_PICK;
            end

            S_MRG_PICK:
            begin
                if (pick_leaf)
                begin
                    lh_next = lh_reg + 1'b1;
                end
                else
                begin
                    ih_next = ih_reg + 1'b1;
                end
                if (!take_reg)
                begin
                    a_next     = pick_node;
                    wa_next    = pick_w;
                    take_next  = 1'b1;
                    state_next = S_MRG_RDO;
                end
                else
                begin
                    b_next     = pick_node;
                    wb_next    = pick_w;
                    state_next = S_MRG_WR0;
                end
            end

            S_MRG_WR0:
            begin
                wgt_we     = 1'b1;
                wgt_waddr  = nx_reg;
                wgt_wdata  = wa_reg + wb_reg;
                kid_we     = 1'b1;
                par_we     = 1'b1;
                state_next = S_MRG_WR1;
            end

            S_MRG_WR1:
            begin
                par_we     = 1'b1;
                par_waddr  = b_reg;
                par_wdata  = {nx_reg, 1'b1};
                nx_next    = nx_reg + 1'b1;
                take_next  = 1'b0;
                state_next = S_MRG_CHK;
            end

            S_ENC_RDW:
            begin
                wgt_raddr  = NB'(cmd_reg.symbol);
                state_next = S_ENC_CHKW;
            end

            S_ENC_CHKW:
            begin
                if (wgt_rdata == '0)
                begin
                    res_next.status = ST_ABSENT;
                    state_next      = S_EMIT;
                end
                else
                begin
                    cur_next   = NB'(cmd_reg.symbol);
                    len_next   = '0;
                    word_next  = '0;
                    state_next = S_ENC_STEP;
                end
            end

            // walk leaf to root, leaf edge lands in bit 0
            S_ENC_STEP:
            begin
                if (cur_reg == root_reg)
                begin
                    if (len_reg > LB'(MAX_CODE_BITS))
                    begin
                        res_next.status = ST_TOO_LONG;
                    end
                    else
                    begin
                        res_next.code_word   = word_reg;
                        res_next.code_length = len_reg[6:0];
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ENC_RDP;
                end
            end

            S_ENC_RDP:
            begin
                if (len_reg < LB'(CODE_WORD_BITS))
                begin
                    word_next[len_reg[5:0]] = par_rdata[0];
                end
                len_next   = len_reg + 1'b1;
                cur_next   = par_rdata[NB:1];
                state_next = S_ENC_STEP;
            end

            S_DEC_RD:
            begin
                state_next = S_DEC_PICK;
            end

            S_DEC_PICK:
            begin
                if (dec_next < NB'(SYMBOLS))
                begin
                    cursor_next         = root_reg;
                    res_next.out_symbol = 8'(dec_next[SB-1:0]);
                    state_next          = S_EMIT;
                end
                else
                begin
                    cursor_next = dec_next;
                    state_next  = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
            scan_reg      <= '0;
            ready_reg     <= 1'b0;
            root_reg      <= '0;
            cursor_reg    <= '0;
            have_prev_reg <= 1'b0;
            found_reg     <= 1'b0;
            nleaf_reg     <= '0;
            take_reg      <= 1'b0;
            lh_reg        <= '0;
            ih_reg        <= '0;
            nx_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            scan_reg      <= scan_next;
            ready_reg     <= ready_next;
            root_reg      <= root_next;
            cursor_reg    <= cursor_next;
            have_prev_reg <= have_prev_next;
            found_reg     <= found_next;
            nleaf_reg     <= nleaf_next;
            take_reg      <= take_next;
            lh_reg        <= lh_next;
            ih_reg        <= ih_next;
            nx_reg        <= nx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rsp_reg    <= rsp_next;
        res_reg    <= res_next;
        prev_w_reg <= prev_w_next;
        prev_s_reg <= prev_s_next;
        best_w_reg <= best_w_next;
        best_s_reg <= best_s_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        wa_reg     <= wa_next;
        wb_reg     <= wb_next;
        lsym_reg   <= lsym_next;
        lw_reg     <= lw_next;
        cur_reg    <= cur_next;
        len_reg    <= len_next;
        word_reg   <= word_next;
    end

    `HFC_ASSERT(a_cursor_internal, ready_reg && !root_leaf, cursor_reg >= NB'(SYMBOLS), "decode cursor left the internal nodes")
    `HFC_ASSERT(a_leaf_head_bound, state_reg == S_MRG_PICK, (lh_reg <= nleaf_reg) && (ih_reg <= nx_reg), "merge queue heads overran")
    `HFC_ASSERT(a_code_len_bound, rsp_valid_reg && (rsp_reg.kind == KIND_CODE) && (rsp_reg.status == ST_OK), rsp_reg.code_length <= 7'(MAX_CODE_BITS), "code length over limit")
    `HFC_ASSERT_NEXT(a_emit_loads, (state_reg == S_EMIT) && (!rsp_valid_reg || rsp_ready), rsp_valid_reg && (state_reg == S_IDLE), "emit did not load rsp")

endmodule

>>> test/huffman_tree_codec_tb.sv
`timescale 1ns / 100ps

module huffman_tree_codec_tb;
    import hfc_pkg::*;

    localparam int NSYM      = SYMBOLS_DEF;
    localparam int NODES     = 2 * NSYM - 1;
    localparam int IDLE_MAX  = 400000;
    localparam int HOLD_LEN  = 400;

    // Tracks the tree the block should hold and the beats still owed on rsp.
    class huff_scoreboard;
        bit [31:0]   counts [NSYM];
        bit [39:0]   weight [NODES];
        int          zero_kid [NODES];
        int          one_kid [NODES];
        int          parent [NODES];
        int          order [NSYM];
        int          order_len;
        int          root;
        int          cursor;
        bit          built;
        rsp_t        owed [$];
        int          errors;

        function new();
            foreach (counts[i]) counts[i] = '0;
            foreach (weight[i])
            begin
                weight[i] = '0;
                zero_kid[i] = 0;
                one_kid[i] = 0;
                parent[i] = 0;
            end
            order_len = 0;
            root = 0;
            cursor = 0;
            built = 0;
            errors = 0;
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            errors++;
        endtask

        // Place n after every entry of weight <= its own.
        function void enqueue(int n);
            int pos;
            pos = 0;
            while (pos < order_len && weight[order[pos]] <= weight[n]) pos++;
            if (order_len >= NSYM) return;
            for (int k = order_len; k > pos; k--) order[k] = order[k-1];
            order[pos] = n;
            order_len++;
        endfunction

        function int grow_tree();
            int leaves, next, a, b;
            leaves = 0;
            next = NSYM;
            order_len = 0;
            for (int s = 0; s < NSYM; s++)
            begin
                weight[s] = {8'd0, counts[s]};
                zero_kid[s] = 0;
                one_kid[s] = 0;
                parent[s] = 0;
                if (counts[s] != 0)
                begin
                    enqueue(s);
                    leaves++;
                end
            end
            while (order_len > 1 && next < NODES)
            begin
                a = order[0];
                b = order[1];
                for (int k = 0; k < order_len - 2; k++) order[k] = order[k+2];
                order_len -= 2;
                weight[next] = weight[a] + weight[b];
                zero_kid[next] = a;
                one_kid[next] = b;
                parent[next] = 0;
                parent[a] = next;
                parent[b] = next;
                enqueue(next);
                next++;
            end
            built = (leaves != 0);
            root = built ? order[0] : 0;
            cursor = root;
            return leaves;
        endfunction

        // Walk leaf to root; bit 0 is the edge next to the leaf.
        task code_of(input int s, output logic [63:0] word, output int len);
            int cur, steps, p;
            word = '0;
            len = 0;
            steps = 0;
            cur = s;
            while (cur != root && steps < NSYM)
            begin
                p = parent[cur];
                if (p >= NODES) break;
                if (len < 64 && one_kid[p] == cur) word[len] = 1'b1;
                len++;
                steps++;
                cur = p;
            end
        endtask

        task note(cmd_t c);
            rsp_t        e;
            logic [63:0] w;
            int          l, nxt;
            e = '0;
            case (op_t'(c.opcode))
                OP_LOAD:
                begin
                    counts[c.symbol] = c.frequency;
                    return;
                end
                OP_BUILD:
                begin
                    e.kind = KIND_BUILD;
                    e.leaf_count = 9'(grow_tree());
                    e.status = built ? ST_OK : ST_NO_TREE;
                end
                OP_ENCODE:
                begin
                    e.kind = KIND_CODE;
                    if (!built) e.status = ST_NO_TREE;
                    else if (weight[c.symbol] == 0) e.status = ST_ABSENT;
                    else
                    begin
                        code_of(c.symbol, w, l);
                        if (l > MAX_CODE_BITS_DEF) e.status = ST_TOO_LONG;
                        else
                        begin
                            e.status = ST_OK;
                            e.code_word = w;
                            e.code_length = 7'(l);
                        end
                    end
                end
                default:
                begin
                    e.kind = KIND_SYM;
                    if (!built) e.status = ST_NO_TREE;
                    else if (root < NSYM)
                    begin
                        e.status = ST_OK;
                        e.out_symbol = 8'(root);
                    end
                    else
                    begin
                        if (cursor >= NODES || cursor < NSYM) cursor = root;
                        nxt = c.coded_bit ? one_kid[cursor] : zero_kid[cursor];
                        if (nxt >= NODES)
                        begin
                            cursor = root;
                            return;
                        end
                        if (nxt >= NSYM)
                        begin
                            cursor = nxt;
                            return;
                        end
                        cursor = root;
                        e.status = ST_OK;
                        e.out_symbol = 8'(nxt);
                    end
                end
            endcase
            owed = {owed, e};
        endtask

        task check(rsp_t r);
            rsp_t e;
            if (owed.size() == 0)
            begin
                report($sformatf("unexpected rsp beat %h", r));
                return;
            end
            e = owed.pop_front();
            if (r.kind !== e.kind)
                report($sformatf("kind %0h, want %0h", r.kind, e.kind));
            if (r.status !== e.status)
                report($sformatf("status %0h, want %0h", r.status, e.status));
            if (r.out_symbol !== e.out_symbol)
                report($sformatf("out_symbol %0h, want %0h", r.out_symbol, e.out_symbol));
            if (r.code_word !== e.code_word)
                report($sformatf("code_word %h, want %h", r.code_word, e.code_word));
            if (r.code_length !== e.code_length)
                report($sformatf("code_length %0d, want %0d", r.code_length, e.code_length));
            if (r.leaf_count !== e.leaf_count)
                report($sformatf("leaf_count %0d, want %0d", r.leaf_count, e.leaf_count));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    huff_scoreboard sb;
    bit   calm;       // no idling on either side in the closing stretch
    bit   hold_req;   // ask the rsp side for one long hold-off
    int   idle_cycles;

    huffman_tree_codec u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Drive one cmd beat starting at a falling edge; return at the falling
    // edge after it is taken. Valid stays up across back-to-back beats.
    task automatic send(op_t op, int s, logic [31:0] freq, logic b);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            cmd_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd = '{opcode: op, symbol: 8'(s), frequency: freq, coded_bit: b};
        do @(posedge clk); while (!cmd_ready);
        @(negedge clk);
        cmd_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1, 2, 3: return 32'($urandom_range(1, 16));
            7:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // A symbol that has a leaf in the current tree, when one can be found.
    function automatic int pick_present();
        int s;
        s = $urandom_range(0, NSYM - 1);
        for (int k = 0; k < 64 && sb.weight[s] == 0; k++) s = $urandom_range(0, NSYM - 1);
        return s;
    endfunction

    // Feed the code of s root first, so the decoder walks a full path.
    task automatic send_code(int s);
        logic [63:0] w;
        int          l;
        sb.code_of(s, w, l);
        if (l > 64) l = 64;
        for (int i = l - 1; i >= 0; i--) send(OP_DECODE, 0, $urandom, w[i]);
    endtask

    task automatic run_mix(int n, int hold_at);
        int r;
        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at) hold_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 12) send(OP_LOAD, $urandom_range(0, 255), pick_count(), 1'($urandom));
            else if (r < 40) send(OP_ENCODE, (r < 34) ? pick_present() : $urandom_range(0, 255),
                                  $urandom, 1'($urandom));
            else if (r < 60) send(OP_DECODE, $urandom_range(0, 255), $urandom, 1'($urandom));
            else send_code(pick_present());
        end
    endtask

    task automatic wait_drained();
        while (sb.owed.size() != 0) @(negedge clk);
    endtask

    // Monitor and watchdog: both channels sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready) sb.note(cmd);
            if (rsp_valid && rsp_ready) sb.check(rsp);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("huffman_tree_codec_tb failed");
                $finish;
            end
        end
    end

    // rsp side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp_ready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp_ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            rsp_ready = 1'b1;
        end
    end

    initial
    begin
        sb = new();
        calm = 1'b0;
        hold_req = 1'b0;
        idle_cycles = 0;
        cmd_valid = 1'b0;
        cmd = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: no tree yet, then an empty build.
        send(OP_ENCODE, 0, '0, 1'b0);
        send(OP_DECODE, 0, '0, 1'b1);
        send(OP_BUILD, 0, '0, 1'b0);
        // Single leaf: zero-length code, every decode bit yields it.
        send(OP_LOAD, 7, 32'd5, 1'b0);
        send(OP_BUILD, 0, '0, 1'b0);
        send(OP_ENCODE, 7, '0, 1'b0);
        send(OP_ENCODE, 8, '0, 1'b0);
        send(OP_DECODE, 0, '0, 1'b0);
        send(OP_DECODE, 0, '0, 1'b1);
        // Quadrupling counts give a deep, lopsided tree; top count at max.
        for (int i = 0; i < 12; i++) send(OP_LOAD, i * 21, 32'd1 << (i * 2), 1'b0);
        send(OP_LOAD, 255, 32'hFFFF_FFFF, 1'b0);
        send(OP_BUILD, 0, '0, 1'b0);
        wait_drained();
        send(OP_ENCODE, 0, '0, 1'b0);
        send(OP_ENCODE, 255, '0, 1'b0);
        send_code(0);
        send_code(255);
        // Loads after a build leave the tree alone.
        send(OP_LOAD, 0, 32'd0, 1'b0);
        send(OP_ENCODE, 0, '0, 1'b0);

        // Random: fill the whole alphabet and build the widest tree.
        for (int s = 0; s < NSYM; s++) send(OP_LOAD, s, pick_count(), 1'($urandom));
        send(OP_BUILD, 0, '0, 1'b0);
        wait_drained();
        run_mix(50, 15);

        // Sender pause until the rsp side has caught up.
        wait_drained();
        for (int i = 0; i < 30; i++)
            send(OP_LOAD, $urandom_range(0, 255), pick_count(), 1'($urandom));
        send(OP_BUILD, 0, '0, 1'b0);
        wait_drained();

        calm = 1'b1;
        run_mix(30, -1);

        wait_drained();
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("huffman_tree_codec_tb passed");
        else
            $display("huffman_tree_codec_tb failed");
        $finish;
    end

endmodule
